>>> src/wildcard_glob_matcher_macros.svh
// ----------------------------------------------------------------------------
// Wildcard glob matcher: assertion macros
// Shorthand for clocked implication checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_MACROS_SVH

// same-cycle implication
`define WGM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wgm checker: same-cycle property failed");

// next-cycle implication
`define WGM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wgm checker: next-cycle property failed");

`endif

>>> src/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

    typedef enum logic [1:0] {
        CMD_PAT_APPEND = 2'd0,
        CMD_VAL_APPEND = 2'd1,
        CMD_EVAL       = 2'd2,
        CMD_PAT_CLEAR  = 2'd3
    } wgm_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_TAIL,
        ST_DONE
    } wgm_state_t;

    localparam logic [7:0] BYTE_ANY  = 8'h3F;  // '?'
    localparam logic [7:0] BYTE_STAR = 8'h2A;  // '*'

    typedef struct packed {
        wgm_cmd_t    cmd;
        logic [7:0]  char_byte;
    } wgm_req_t;

    typedef struct packed {
        logic is_match;
        logic overflowed;
    } wgm_rsp_t;

    // top -> sequencer
    typedef struct packed {
        logic go;
        logic ovf;
    } wgm_seq_ctl_t;

    // sequencer -> top
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
        logic ovf;
    } wgm_seq_sts_t;

endpackage

>>> src/wgm_ram.sv
// ----------------------------------------------------------------------------
// wgm_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wgm_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/wgm_seq.sv
// ----------------------------------------------------------------------------
// wgm_seq
// Match sequencer: walks pattern and value stores, one step per cycle,
// backtracking to the most recent star.
// ----------------------------------------------------------------------------
module wgm_seq #(
    parameter int PLW = 7,
    parameter int PAW = 6,
    parameter int VLW = 9,
    parameter int VAW = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wgm_pkg::wgm_seq_ctl_t ctl,
    input  logic [PLW-1:0]        plen,
    input  logic [VLW-1:0]        vlen,
    input  logic [7:0]            pat_rdata,
    input  logic [7:0]            val_rdata,
    output logic [PAW-1:0]        pat_raddr,
    output logic [VAW-1:0]        val_raddr,
    output wgm_pkg::wgm_seq_sts_t sts
);

    wgm_pkg::wgm_state_t state_reg, state_next;
    logic [PLW-1:0] pi_reg, pi_next;
    logic [VLW-1:0] vi_reg, vi_next;
    logic           star_reg, star_next;
    logic [PLW-1:0] star_at_reg, star_at_next;
    logic [VLW-1:0] resume_reg, resume_next;
    logic           hit_reg, hit_next;
    logic           ovf_reg, ovf_next;
    logic           p_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wgm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg      <= pi_next;
        vi_reg      <= vi_next;
        star_reg    <= star_next;
        star_at_reg <= star_at_next;
        resume_reg  <= resume_next;
        hit_reg     <= hit_next;
        ovf_reg     <= ovf_next;
    end

    // read data always belongs to the current indices: address follows *_next
    always_comb
    begin
        state_next   = state_reg;
        pi_next      = pi_reg;
        vi_next      = vi_reg;
        star_next    = star_reg;
        star_at_next = star_at_reg;
        resume_next  = resume_reg;
        hit_next     = hit_reg;
        ovf_next     = ovf_reg;
        p_valid      = (pi_reg < plen);

        case (state_reg)
            wgm_pkg::ST_IDLE:
            begin
                if (ctl.go)
                begin
                    pi_next   = '0;
                    vi_next   = '0;
                    star_next = 1'b0;
                    ovf_next  = ctl.ovf;
                    hit_next  = 1'b0;
                    state_next = ctl.ovf ? wgm_pkg::ST_DONE : wgm_pkg::ST_MATCH;
                end
            end
            wgm_pkg::ST_MATCH:
            begin
                if (vi_reg >= vlen)
                begin
                    state_next = wgm_pkg::ST_TAIL;
                end
                else if (p_valid && (pat_rdata == wgm_pkg::BYTE_ANY ||
                                     pat_rdata == val_rdata))
                begin
                    pi_next = pi_reg + PLW'(1);
                    vi_next = vi_reg + VLW'(1);
                end
                else if (p_valid && pat_rdata == wgm_pkg::BYTE_STAR)
                begin
                    star_next    = 1'b1;
                    star_at_next = pi_reg;
                    pi_next      = pi_reg + PLW'(1);
                    resume_next  = vi_reg;
                end
                else if (star_reg)
                begin
                    pi_next     = star_at_reg + PLW'(1);
                    resume_next = resume_reg + VLW'(1);
                    vi_next     = resume_reg + VLW'(1);
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = wgm_pkg::ST_DONE;
                end
            end
            wgm_pkg::ST_TAIL:
            begin
                // skip trailing stars, then the whole pattern must be used
                if (p_valid && pat_rdata == wgm_pkg::BYTE_STAR)
                begin
                    pi_next = pi_reg + PLW'(1);
                end
                else
                begin
                    hit_next   = (pi_reg == plen);
                    state_next = wgm_pkg::ST_DONE;
                end
            end
            wgm_pkg::ST_DONE:
            begin
                state_next = wgm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wgm_pkg::ST_IDLE;
            end
        endcase
    end

    assign pat_raddr = pi_next[PAW-1:0];
    assign val_raddr = vi_next[VAW-1:0];

    assign sts.busy = (state_reg != wgm_pkg::ST_IDLE);
    assign sts.done = (state_reg == wgm_pkg::ST_DONE);
    assign sts.hit  = hit_reg;
    assign sts.ovf  = ovf_reg;

endmodule

>>> src/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Loads pattern and value bytes into stores and matches them on evaluate.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------
//   command   | start / busy         | req (cmd, char_byte)
//   result    | done (1-cycle pulse) | rsp (is_match, overflowed)
//
// Append and clear commands leave busy low. Evaluate keeps busy high through
// the walk steps (backtracking included), the trailing stars, an end check each
// for value and pattern, and the result state; a dead mismatch skips the end
// checks, and an overflowed store goes straight to the result.
// The result strobe is the last busy cycle; the value store empties then.
// Reset clears lengths and flags, not store contents; the receiver cannot stall.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
    parameter int PATTERN_DEPTH = 64,
    parameter int VALUE_DEPTH   = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  wgm_pkg::wgm_req_t req,
    output logic              done,
    output wgm_pkg::wgm_rsp_t rsp
);

    localparam int PLW = $clog2(PATTERN_DEPTH + 1);
    localparam int VLW = $clog2(VALUE_DEPTH + 1);
    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int VAW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

    logic [PLW-1:0] plen_reg, plen_next;
    logic [VLW-1:0] vlen_reg, vlen_next;
    logic           povf_reg, povf_next;
    logic           vovf_reg, vovf_next;

    logic           accept;
    logic           pat_we, val_we;
    logic [PAW-1:0] pat_raddr;
    logic [VAW-1:0] val_raddr;
    logic [7:0]     pat_rdata, val_rdata;

    wgm_pkg::wgm_seq_ctl_t ctl;
    wgm_pkg::wgm_seq_sts_t sts;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            vlen_reg <= '0;
            povf_reg <= 1'b0;
            vovf_reg <= 1'b0;
        end
        else
        begin
            plen_reg <= plen_next;
            vlen_reg <= vlen_next;
            povf_reg <= povf_next;
            vovf_reg <= vovf_next;
        end
    end

    always_comb
    begin
        plen_next = plen_reg;
        vlen_next = vlen_reg;
        povf_next = povf_reg;
        vovf_next = vovf_reg;
        pat_we    = 1'b0;
        val_we    = 1'b0;

        if (accept)
        begin
            case (req.cmd)
                wgm_pkg::CMD_PAT_APPEND:
                begin
                    if (plen_reg < PLW'(PATTERN_DEPTH))
                    begin
                        pat_we    = 1'b1;
                        plen_next = plen_reg + PLW'(1);
                    end
                    else
                    begin
                        povf_next = 1'b1;
                    end
                end
                wgm_pkg::CMD_VAL_APPEND:
                begin
                    if (vlen_reg < VLW'(VALUE_DEPTH))
                    begin
                        val_we    = 1'b1;
                        vlen_next = vlen_reg + VLW'(1);
                    end
                    else
                    begin
                        vovf_next = 1'b1;
                    end
                end
                wgm_pkg::CMD_PAT_CLEAR:
                begin
                    plen_next = '0;
                    povf_next = 1'b0;
                end
                default:
                begin
                    // evaluate: handled by the sequencer
                end
            endcase
        end

        // value is consumed by the evaluate: cleared on its result strobe
        if (sts.done)
        begin
            vlen_next = '0;
            vovf_next = 1'b0;
        end
    end

    assign ctl.go  = accept && (req.cmd == wgm_pkg::CMD_EVAL);
    assign ctl.ovf = povf_reg || vovf_reg;

    wgm_ram #(
        .DEPTH (PATTERN_DEPTH),
        .AW    (PAW)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (plen_reg[PAW-1:0]),
        .wdata (req.char_byte),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    wgm_ram #(
        .DEPTH (VALUE_DEPTH),
        .AW    (VAW)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (vlen_reg[VAW-1:0]),
        .wdata (req.char_byte),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    wgm_seq #(
        .PLW (PLW),
        .PAW (PAW),
        .VLW (VLW),
        .VAW (VAW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .plen      (plen_reg),
        .vlen      (vlen_reg),
        .pat_rdata (pat_rdata),
        .val_rdata (val_rdata),
        .pat_raddr (pat_raddr),
        .val_raddr (val_raddr),
        .sts       (sts)
    );

    assign busy           = sts.busy;
    assign done           = sts.done;
    assign rsp.is_match   = sts.hit && !sts.ovf;
    assign rsp.overflowed = sts.ovf;

endmodule

>>> src/wgm_checker.sv
// ----------------------------------------------------------------------------
// wgm_checker
// Port-level checks on the glob matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "wildcard_glob_matcher_macros.svh"

module wgm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input wgm_pkg::wgm_req_t req,
    input logic              done,
    input wgm_pkg::wgm_rsp_t rsp
);

    logic acc_eval;
    logic acc_other;

    assign acc_eval  = start && !busy && (req.cmd == wgm_pkg::CMD_EVAL);
    assign acc_other = start && !busy && (req.cmd != wgm_pkg::CMD_EVAL);

    // a result only comes out of an evaluate in flight
    `WGM_ASSERT_NOW(a_done_busy, done, busy)
    // overflow always forces no-match
    `WGM_ASSERT_NOW(a_ovf_nomatch, done && rsp.overflowed, !rsp.is_match)
    // load and clear transfers finish at once
    `WGM_ASSERT_NXT(a_load_quick, acc_other, !busy && !done)
    // evaluate always starts the sequencer
    `WGM_ASSERT_NXT(a_eval_busy, acc_eval, busy)
    // the result ends the evaluate
    `WGM_ASSERT_NXT(a_done_ends, done, !busy && !done)

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher testbench
// Loads pattern and value strings through the command port, evaluates them
// and checks each result against a bench software glob matcher or a typed-in value.
// A short table of directed commands comes first. Forced store overflows
// and random load/evaluate sequences with sender gaps follow.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_DEPTH    = 64;
    localparam int VAL_DEPTH    = 256;
    localparam int ITEMS_TARGET = 950;
    localparam int CALM_TAIL    = 120;
    localparam int QUIET_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 20;

    localparam wgm_pkg::wgm_rsp_t NO_RSP = '0;

    typedef struct packed {
        wgm_pkg::wgm_req_t item;
        logic              fixed;
        wgm_pkg::wgm_rsp_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    // typed-in results only where they are obvious; other evaluations use the predictor
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{'{wgm_pkg::CMD_EVAL,       8'h00}, 1'b1, '{1'b1, 1'b0}},  // empty pattern, empty value
        '{'{wgm_pkg::CMD_VAL_APPEND, "a"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_EVAL,       8'h00}, 1'b1, '{1'b0, 1'b0}},  // empty pattern, value "a"
        '{'{wgm_pkg::CMD_PAT_APPEND, "*"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_EVAL,       8'hA5}, 1'b1, '{1'b1, 1'b0}},  // star matches empty value
        '{'{wgm_pkg::CMD_PAT_APPEND, "?"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_PAT_APPEND, "C"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, "x"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, "y"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, "C"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_EVAL,       8'h00}, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, "c"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_EVAL,       8'hFF}, 1'b0, NO_RSP},        // miss: value too short for the pattern
        '{'{wgm_pkg::CMD_PAT_CLEAR,  8'hFF}, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_EVAL,       8'h00}, 1'b1, '{1'b1, 1'b0}},  // cleared pattern
        '{'{wgm_pkg::CMD_PAT_APPEND, "*"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_PAT_APPEND, "a"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_PAT_APPEND, "b"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, "a"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, "a"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, "b"  }, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_EVAL,       8'h00}, 1'b0, NO_RSP},        // needs a backtrack
        '{'{wgm_pkg::CMD_PAT_APPEND, 8'hFF}, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, 8'h00}, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_VAL_APPEND, 8'hFF}, 1'b0, NO_RSP},
        '{'{wgm_pkg::CMD_EVAL,       8'h00}, 1'b0, NO_RSP}
    };

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    wgm_pkg::wgm_req_t req   = '0;
    logic              busy;
    logic              done;
    wgm_pkg::wgm_rsp_t rsp;

    // predictor state
    logic [7:0] pat_mem [PAT_DEPTH];
    bit   [6:0] pat_len;
    bit         pat_ovf;
    logic [7:0] val_mem [VAL_DEPTH];
    bit   [8:0] val_len;
    bit         val_ovf;

    wgm_pkg::wgm_rsp_t pending_results [$];

    int  items_taken;
    int  results_seen;
    int  hits;
    int  ovf_results;
    int  errs;
    int  quiet;
    int  taken_last;
    bit  calm;

    wildcard_glob_matcher #(
        .PATTERN_DEPTH (PAT_DEPTH),
        .VALUE_DEPTH   (VAL_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #10 clk = ~clk;

    // greedy glob walk, backtracking only to the latest star
    function automatic bit glob_eval();
        int unsigned pi;
        int unsigned vi;
        int unsigned star_pos;
        int unsigned resume_pos;
        bit          seen_star;
        pi = 0;
        vi = 0;
        star_pos = 0;
        resume_pos = 0;
        seen_star = 1'b0;
        while (vi < val_len)
        begin
            if (pi < pat_len && (pat_mem[pi] == wgm_pkg::BYTE_ANY ||
                                 pat_mem[pi] == val_mem[vi]))
            begin
                pi++;
                vi++;
            end
            else if (pi < pat_len && pat_mem[pi] == wgm_pkg::BYTE_STAR)
            begin
                seen_star = 1'b1;
                star_pos = pi;
                pi++;
                resume_pos = vi;
            end
            else if (seen_star)
            begin
                pi = star_pos + 1;
                resume_pos++;
                vi = resume_pos;
            end
            else
            begin
                return 1'b0;
            end
        end
        while (pi < pat_len && pat_mem[pi] == wgm_pkg::BYTE_STAR)
            pi++;
        return pi == pat_len;
    endfunction

    function automatic void apply_command(wgm_pkg::wgm_req_t r, bit fixed,
                                          wgm_pkg::wgm_rsp_t want);
        wgm_pkg::wgm_rsp_t got;
        case (r.cmd)
            wgm_pkg::CMD_PAT_APPEND:
            begin
                if (pat_len < PAT_DEPTH)
                begin
                    pat_mem[pat_len] = r.char_byte;
                    pat_len++;
                end
                else
                begin
                    pat_ovf = 1'b1;
                end
            end
            wgm_pkg::CMD_VAL_APPEND:
            begin
                if (val_len < VAL_DEPTH)
                begin
                    val_mem[val_len] = r.char_byte;
                    val_len++;
                end
                else
                begin
                    val_ovf = 1'b1;
                end
            end
            wgm_pkg::CMD_EVAL:
            begin
                got.overflowed = pat_ovf | val_ovf;
                got.is_match = got.overflowed ? 1'b0 : glob_eval();
                pending_results = {pending_results, (fixed ? want : got)};
                val_len = '0;
                val_ovf = 1'b0;
            end
            default:
            begin
                pat_len = '0;
                pat_ovf = 1'b0;
            end
        endcase
    endfunction

    // present one command and hold it until the transfer happens
    task automatic issue(input wgm_pkg::wgm_req_t r, input bit fixed,
                         input wgm_pkg::wgm_rsp_t want);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_taken++;
        apply_command(r, fixed, want);
    endtask

    task automatic put(input wgm_pkg::wgm_cmd_t c, input logic [7:0] b);
        wgm_pkg::wgm_req_t r;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        r.cmd = c;
        r.char_byte = b;
        issue(r, 1'b0, NO_RSP);
    endtask

    function automatic logic [7:0] pick_literal();
        case ($urandom_range(0, 3))
            0: return "a";
            1: return "b";
            2: return "A";
            default: return "c";
        endcase
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return wgm_pkg::BYTE_STAR;
        else if (r < 30)
            return wgm_pkg::BYTE_ANY;
        else if (r < 90)
            return pick_literal();
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic load_pattern(input int n);
        put(wgm_pkg::CMD_PAT_CLEAR, 8'($urandom_range(0, 255)));
        repeat (n) put(wgm_pkg::CMD_PAT_APPEND, pick_pattern_byte());
    endtask

    // value mostly built to fit the current pattern, then maybe spoiled
    task automatic load_value();
        logic [7:0] vq [$];
        int         k;
        if ($urandom_range(0, 9) < 7)
        begin
            for (int i = 0; i < pat_len; i++)
            begin
                if (pat_mem[i] == wgm_pkg::BYTE_STAR)
                    repeat ($urandom_range(0, 3)) vq = {vq, pick_literal()};
                else if (pat_mem[i] == wgm_pkg::BYTE_ANY)
                    vq = {vq, 8'($urandom_range(0, 255))};
                else
                    vq = {vq, pat_mem[i]};
            end
            if (vq.size() > 0 && $urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(0, vq.size() - 1);
                case ($urandom_range(0, 2))
                    0: vq[k] = pick_literal();
                    1: vq.delete(k);
                    default: vq.insert(k, pick_literal());
                endcase
            end
        end
        else
        begin
            repeat ($urandom_range(0, 10)) vq = {vq, pick_literal()};
        end
        foreach (vq[i])
            put(wgm_pkg::CMD_VAL_APPEND, vq[i]);
    endtask

    task automatic evaluate();
        put(wgm_pkg::CMD_EVAL, 8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_pattern_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 8);
        else if (r < 97)
            return $urandom_range(9, 24);
        else
            return $urandom_range(25, PAT_DEPTH);
    endfunction

    task automatic overflow_pattern();
        load_pattern(PAT_DEPTH + $urandom_range(1, 3));
        load_value();
        evaluate();
        evaluate();  // pattern flag survives an evaluate
    endtask

    task automatic overflow_value();
        load_pattern(1);
        repeat (VAL_DEPTH + $urandom_range(1, 3))
            put(wgm_pkg::CMD_VAL_APPEND, 8'($urandom_range(0, 255)));
        evaluate();
        evaluate();  // value flag is gone again
    endtask

    always @(posedge clk)
    begin
        wgm_pkg::wgm_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: is_match=%0b overflowed=%0b",
                       rsp.is_match, rsp.overflowed);
                errs++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (rsp.is_match) hits++;
                if (rsp.overflowed) ovf_results++;
                if (rsp.is_match !== want.is_match)
                begin
                    $error("is_match: expected %0b, got %0b", want.is_match, rsp.is_match);
                    errs++;
                end
                if (rsp.overflowed !== want.overflowed)
                begin
                    $error("overflowed: expected %0b, got %0b",
                           want.overflowed, rsp.overflowed);
                    errs++;
                end
            end
        end
    end

    // watchdog: cycles with neither a command transfer nor a result
    always @(posedge clk)
    begin
        if (!rst_n || done || items_taken != taken_last)
            quiet = 0;
        else
            quiet++;
        taken_last = items_taken;
        if (quiet >= QUIET_LIMIT)
        begin
            $error("no transfer for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int sel;
        pat_len = '0;
        pat_ovf = 1'b0;
        val_len = '0;
        val_ovf = 1'b0;
        calm = 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            issue(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);

        calm = 1'b0;
        overflow_pattern();
        overflow_value();

        while (items_taken < ITEMS_TARGET)
        begin
            calm = (items_taken > ITEMS_TARGET - CALM_TAIL) || ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 199);
            if (sel < 16)
            begin
                repeat ($urandom_range(1, 4))
                    put(wgm_pkg::wgm_cmd_t'($urandom_range(0, 3)),
                        8'($urandom_range(0, 255)));
            end
            else if (sel < 22)
            begin
                overflow_pattern();
            end
            else if (sel < 23)
            begin
                overflow_value();
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    load_pattern(pick_pattern_len());
                load_value();
                evaluate();
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands transferred, %0d evaluations checked", items_taken, results_seen);
        $display("(%0d matched, %0d reported store overflow)", hits, ovf_results);
        if (errs == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
